// ===== rtl/pai_pkg.sv =====
// Shared types and codes for the positional array insert and delete unit.
package pai_pkg;

    // Command codes carried in the command field.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    // Status codes carried in the result.
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_BAD_POS = 2'd1,
        STS_FULL    = 2'd2,
        STS_EMPTY   = 2'd3
    } t_status;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CH_HOLD   = 3'd0,
        CH_INSERT = 3'd1,
        CH_DELETE = 3'd2,
        CH_UPDATE = 3'd3,
        CH_ROTATE = 3'd4
    } t_chain_op;

    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    // A dump shows at most this many entries.
    localparam int DUMP_MAX = 16;

    typedef struct packed {
        t_chain_op          op;
        logic [POS_W-1:0]   pos;
    } t_chain_ctrl;

endpackage

// ===== rtl/pai_if.sv =====
// Command and result channel interfaces of the positional array unit.
interface pai_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [4:0]         position;
    logic signed [31:0] value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink (input valid, input command, input position, input value,
                  output ready);
endinterface

interface pai_res_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [3:0]         entry_index;
    logic [4:0]         entry_count;
    logic               last;

    modport source (output valid, output status, output read_value,
                    output entry_index, output entry_count, output last,
                    input ready);
    modport sink (input valid, input status, input read_value,
                  input entry_index, input entry_count, input last,
                  output ready);
endinterface

// ===== rtl/pai_cell.sv =====
// One storage cell of the entry chain, loading from its neighbours, the head cell or the bus.
module pai_cell #(
    parameter int IDX_W = 5,
    parameter int INDEX = 0
) (
    input  logic                              i_clk,
    input  pai_pkg::t_chain_ctrl              i_ctrl,
    input  logic [IDX_W-1:0]                  i_limit,
    input  logic signed [pai_pkg::VALUE_W-1:0] i_left,
    input  logic signed [pai_pkg::VALUE_W-1:0] i_right,
    input  logic signed [pai_pkg::VALUE_W-1:0] i_head,
    input  logic signed [pai_pkg::VALUE_W-1:0] i_value,
    output logic signed [pai_pkg::VALUE_W-1:0] o_entry
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [pai_pkg::VALUE_W-1:0] r_entry;
    logic signed [pai_pkg::VALUE_W-1:0] n_entry;
    logic [IDX_W-1:0]                   pos_ext;

    assign pos_ext = IDX_W'(i_ctrl.pos);

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctrl.op)
            pai_pkg::CH_INSERT: begin
                // Cells above the insertion point move up by one place.
                if (MY_IDX == pos_ext) begin
                    n_entry = i_value;
                end else if (MY_IDX > pos_ext && MY_IDX <= i_limit) begin
                    n_entry = i_left;
                end
            end
            pai_pkg::CH_DELETE: begin
                if (MY_IDX >= pos_ext && MY_IDX < i_limit) begin
                    n_entry = i_right;
                end
            end
            pai_pkg::CH_UPDATE: begin
                if (MY_IDX == pos_ext) begin
                    n_entry = i_value;
                end
            end
            pai_pkg::CH_ROTATE: begin
                // The occupied part of the chain turns one place towards the head.
                if (MY_IDX < i_limit) begin
                    n_entry = i_right;
                end else if (MY_IDX == i_limit) begin
                    n_entry = i_head;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/positional_array_insert_delete_unit.sv =====
// Top level of the positional array insert and delete unit.
//
// Commands arrive on i_cmd and results leave on o_res, each a valid/ready
// channel; a transaction completes when valid and ready are both high.
// Insert, delete and update each give one result, registered in the cycle after
// the command transaction; a new command is taken every cycle as long as the
// receiver takes the results.
// A dump gives one result per stored entry (at most sixteen are shown). It
// takes the command and then turns the chain of cells by one place for each
// stored entry, loading the head entry into each result and holding while the
// receiver stalls; no command is taken meanwhile. A dump of an empty list
// gives a single empty status.
// Results wait in the output register while the receiver stalls; the chain
// only moves when a result can be loaded, but for entries past the shown ones in a dump.
// Reset clears the entry count and the output valid flag; the entries
// themselves are not cleared and are never read before being written.
module positional_array_insert_delete_unit #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pai_cmd_if.sink   i_cmd,
    pai_res_if.source o_res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > pai_pkg::POS_W) ? CW : pai_pkg::POS_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_idx, n_idx;

    logic                              r_out_valid, n_out_valid;
    pai_pkg::t_status                  r_status, n_status;
    logic signed [pai_pkg::VALUE_W-1:0] r_read_value, n_read_value;
    logic [pai_pkg::INDEX_W-1:0]       r_entry_index, n_entry_index;
    logic [pai_pkg::COUNT_W-1:0]       r_entry_count, n_entry_count;
    logic                              r_last, n_last;

    pai_pkg::t_chain_ctrl              chain_ctrl;
    logic [PW-1:0]                     chain_limit;
    logic signed [pai_pkg::VALUE_W-1:0] cell_q [DEPTH];

    logic          out_free;
    logic          cmd_take;
    logic [PW-1:0] count_ext;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] dump_last;
    logic [PW-1:0] n_count_ext;

    assign out_free    = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign cmd_take    = i_cmd.valid && i_cmd.ready;
    assign count_ext   = PW'(r_count);
    assign pos_ext     = PW'(i_cmd.position);
    assign dump_last   = (count_ext > PW'(pai_pkg::DUMP_MAX)) ?
                         PW'(pai_pkg::DUMP_MAX - 1) : (count_ext - PW'(1));
    assign n_count_ext = PW'(n_count);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_status      = r_status;
        n_read_value  = r_read_value;
        n_entry_index = r_entry_index;
        n_entry_count = r_entry_count;
        n_last        = r_last;
        chain_ctrl.op  = pai_pkg::CH_HOLD;
        chain_ctrl.pos = i_cmd.position;
        chain_limit    = count_ext;

        unique case (r_state)
            S_IDLE: begin
                if (cmd_take) begin
                    n_status      = pai_pkg::STS_OK;
                    n_read_value  = '0;
                    n_entry_index = '0;
                    n_last        = 1'b1;
                    n_out_valid   = 1'b1;
                    unique case (pai_pkg::t_cmd'(i_cmd.command))
                        pai_pkg::CMD_INSERT: begin
                            if (pos_ext > count_ext) begin
                                n_status = pai_pkg::STS_BAD_POS;
                            end else if (count_ext == PW'(DEPTH)) begin
                                n_status = pai_pkg::STS_FULL;
                            end else begin
                                chain_ctrl.op = pai_pkg::CH_INSERT;
                                n_count       = r_count + CW'(1);
                            end
                        end
                        pai_pkg::CMD_DELETE: begin
                            chain_limit = count_ext - PW'(1);
                            if (pos_ext >= count_ext) begin
                                n_status = pai_pkg::STS_BAD_POS;
                            end else begin
                                chain_ctrl.op = pai_pkg::CH_DELETE;
                                n_count       = r_count - CW'(1);
                            end
                        end
                        pai_pkg::CMD_UPDATE: begin
                            if (pos_ext >= count_ext) begin
                                n_status = pai_pkg::STS_BAD_POS;
                            end else begin
                                chain_ctrl.op = pai_pkg::CH_UPDATE;
                            end
                        end
                        pai_pkg::CMD_DUMP: begin
                            if (r_count == '0) begin
                                n_status = pai_pkg::STS_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_idx       = '0;
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                            n_status = pai_pkg::STS_OK;
                        end
                    endcase
                    n_entry_count = n_count_ext[pai_pkg::COUNT_W-1:0];
                end
            end
            S_DUMP: begin
                chain_limit = count_ext - PW'(1);
                // Entries past the shown ones still turn so that the order is restored.
                if (r_idx >= PW'(pai_pkg::DUMP_MAX) || out_free) begin
                    chain_ctrl.op = pai_pkg::CH_ROTATE;
                    if (r_idx < PW'(pai_pkg::DUMP_MAX)) begin
                        n_out_valid   = 1'b1;
                        n_status      = pai_pkg::STS_OK;
                        n_read_value  = cell_q[0];
                        n_entry_index = r_idx[pai_pkg::INDEX_W-1:0];
                        n_entry_count = count_ext[pai_pkg::COUNT_W-1:0];
                        n_last        = (r_idx == dump_last);
                    end
                    if (r_idx == count_ext - PW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + PW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status      <= n_status;
        r_read_value  <= n_read_value;
        r_entry_index <= n_entry_index;
        r_entry_count <= n_entry_count;
        r_last        <= n_last;
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [pai_pkg::VALUE_W-1:0] left_q;
        logic signed [pai_pkg::VALUE_W-1:0] right_q;

        if (k == 0) begin : g_head
            assign left_q = '0;
        end else begin : g_mid
            assign left_q = cell_q[k-1];
        end
        if (k == DEPTH - 1) begin : g_tail
            assign right_q = '0;
        end else begin : g_body
            assign right_q = cell_q[k+1];
        end

        pai_cell #(
            .IDX_W (PW),
            .INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (chain_ctrl),
            .i_limit (chain_limit),
            .i_left  (left_q),
            .i_right (right_q),
            .i_head  (cell_q[0]),
            .i_value (i_cmd.value),
            .o_entry (cell_q[k])
        );
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.read_value  = r_read_value;
    assign o_res.entry_index = r_entry_index;
    assign o_res.entry_count = r_entry_count;
    assign o_res.last        = r_last;

endmodule

// ===== tb/positional_array_insert_delete_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the positional array insert and delete unit.
module positional_array_insert_delete_unit_tb;

    localparam int ARRAY_DEPTH = 16;

    typedef struct {
        pai_pkg::t_status   status;
        logic signed [31:0] read_value;
        logic [3:0]         entry_index;
        logic [4:0]         entry_count;
        logic               last;
    } t_list_result;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pai_cmd_if cmd_ch ();
    pai_res_if res_ch ();

    positional_array_insert_delete_unit #(.DEPTH(ARRAY_DEPTH)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    // Shadow copy of the list, updated when each command transaction completes.
    logic signed [31:0] list_entries [ARRAY_DEPTH];
    int                 list_count = 0;
    t_list_result       awaited_results [$];
    int                 failures = 0;

    int send_stretch = 0;
    bit send_quiet   = 1'b0;
    int recv_stretch = 0;
    bit recv_quiet   = 1'b0;

    always #5 clk = ~clk;

    // Waits come in stretches, some of which have no waits at all.
    function automatic int draw_wait(ref int stretch_left, ref bit quiet);
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(8, 40);
            quiet = ($urandom_range(0, 3) == 0);
        end
        stretch_left--;
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic void apply_list_command(pai_pkg::t_cmd cmd, logic [4:0] pos,
                                               logic signed [31:0] val);
        t_list_result res;
        int           shown;
        res.status      = pai_pkg::STS_OK;
        res.read_value  = 32'sd0;
        res.entry_index = 4'd0;
        res.entry_count = 5'd0;
        res.last        = 1'b1;
        case (cmd)
            pai_pkg::CMD_INSERT: begin
                if (pos > list_count) begin
                    res.status = pai_pkg::STS_BAD_POS;
                end else if (list_count >= ARRAY_DEPTH) begin
                    res.status = pai_pkg::STS_FULL;
                end else begin
                    for (int i = list_count; i > pos; i--)
                        list_entries[i] = list_entries[i - 1];
                    list_entries[pos] = val;
                    list_count++;
                end
            end
            pai_pkg::CMD_DELETE: begin
                if (pos >= list_count) begin
                    res.status = pai_pkg::STS_BAD_POS;
                end else begin
                    for (int i = pos; i + 1 < list_count; i++)
                        list_entries[i] = list_entries[i + 1];
                    list_count--;
                end
            end
            pai_pkg::CMD_UPDATE: begin
                if (pos >= list_count)
                    res.status = pai_pkg::STS_BAD_POS;
                else
                    list_entries[pos] = val;
            end
            default: begin
                if (list_count == 0) begin
                    res.status = pai_pkg::STS_EMPTY;
                end else begin
                    shown = (list_count < pai_pkg::DUMP_MAX) ? list_count
                                                             : pai_pkg::DUMP_MAX;
                    for (int i = 0; i < shown; i++) begin
                        res.read_value  = list_entries[i];
                        res.entry_index = 4'(i);
                        res.entry_count = 5'(list_count);
                        res.last        = (i == shown - 1);
                        awaited_results.push_back(res);
                    end
                    return;
                end
            end
        endcase
        res.entry_count = 5'(list_count);
        awaited_results.push_back(res);
    endfunction

    // Leaves valid high on return, so that a following call can keep it high.
    task automatic send_command(pai_pkg::t_cmd cmd, logic [4:0] pos,
                                logic signed [31:0] val);
        int gap;
        gap = draw_wait(send_stretch, send_quiet);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= cmd;
        cmd_ch.position <= pos;
        cmd_ch.value    <= val;
        do @(posedge clk); while (!cmd_ch.ready);
        apply_list_command(cmd, pos, val);
    endtask

    task automatic test_empty_list();
        send_command(pai_pkg::CMD_DUMP, 5'd0, 32'sd0);
        send_command(pai_pkg::CMD_DELETE, 5'd0, 32'sd0);
        send_command(pai_pkg::CMD_UPDATE, 5'd0, 32'sd7);
        send_command(pai_pkg::CMD_INSERT, 5'd31, 32'sd1);
    endtask

    task automatic test_fill_to_capacity();
        send_command(pai_pkg::CMD_INSERT, 5'd0, 32'sh8000_0000);
        send_command(pai_pkg::CMD_INSERT, 5'd1, 32'sh7fff_ffff);
        send_command(pai_pkg::CMD_INSERT, 5'd1, 32'sd0);
        send_command(pai_pkg::CMD_INSERT, 5'd0, -32'sd1);
        while (list_count < ARRAY_DEPTH)
            send_command(pai_pkg::CMD_INSERT, 5'($urandom_range(0, list_count)),
                         $urandom);
        // A full list reports full for an in-range position but a bad
        // position first when the position is beyond the end.
        send_command(pai_pkg::CMD_INSERT, 5'd8, 32'sd5);
        send_command(pai_pkg::CMD_INSERT, 5'd16, 32'sd5);
        send_command(pai_pkg::CMD_INSERT, 5'd17, 32'sd5);
        send_command(pai_pkg::CMD_DUMP, 5'd0, 32'sd0);
    endtask

    task automatic test_edits_at_ends();
        send_command(pai_pkg::CMD_UPDATE, 5'd15, 32'sh1234_5678);
        send_command(pai_pkg::CMD_UPDATE, 5'd0, 32'shedcb_a987);
        send_command(pai_pkg::CMD_UPDATE, 5'd16, 32'sd3);
        send_command(pai_pkg::CMD_DELETE, 5'd0, 32'sd0);
        send_command(pai_pkg::CMD_DELETE, 5'd15, 32'sd0);
        send_command(pai_pkg::CMD_DELETE, 5'd14, 32'sd0);
        send_command(pai_pkg::CMD_DUMP, 5'd9, 32'sd0);
    endtask

    task automatic test_random_edits(int items, int insert_pct, int delete_pct);
        pai_pkg::t_cmd      cmd;
        logic [4:0]         pos;
        logic signed [31:0] val;
        int                 roll;
        repeat (items) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct)
                cmd = pai_pkg::CMD_INSERT;
            else if (roll < insert_pct + delete_pct)
                cmd = pai_pkg::CMD_DELETE;
            else if (roll[0])
                cmd = pai_pkg::CMD_UPDATE;
            else
                cmd = pai_pkg::CMD_DUMP;
            // Most positions are in range for the command; the rest may be anything.
            if ($urandom_range(0, 7) == 0)
                pos = 5'($urandom_range(0, 31));
            else if (cmd == pai_pkg::CMD_INSERT)
                pos = 5'($urandom_range(0, list_count));
            else if (list_count > 0)
                pos = 5'($urandom_range(0, list_count - 1));
            else
                pos = 5'd0;
            case ($urandom_range(0, 9))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7fff_ffff;
                default: val = $urandom;
            endcase
            send_command(cmd, pos, val);
        end
    endtask

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
            failures++;
        end
    endfunction

    always @(posedge clk) begin
        t_list_result want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: status %0d, read_value %0d",
                       res_ch.status, res_ch.read_value);
                failures++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", 32'(want.status), 32'(res_ch.status));
                check_field("read_value", want.read_value, res_ch.read_value);
                check_field("entry_index", 32'(want.entry_index),
                            32'(res_ch.entry_index));
                check_field("entry_count", 32'(want.entry_count),
                            32'(res_ch.entry_count));
                check_field("last", 32'(want.last), 32'(res_ch.last));
            end
        end
    end

    initial begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = draw_wait(recv_stretch, recv_quiet);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    initial begin : stimulus
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = pai_pkg::CMD_INSERT;
        cmd_ch.position = 5'd0;
        cmd_ch.value    = 32'sd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_fill_to_capacity();
        test_edits_at_ends();
        test_random_edits(50, 70, 10);
        test_random_edits(50, 15, 55);
        test_random_edits(50, 35, 30);

        cmd_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
